// ===== src/bdmc_pkg.sv =====
// Shared types, register indexes and reset values of the debounced button CC block.
package bdmc_pkg;

   localparam int NUM_BUTTONS_DEF = 3;
   localparam int INPUT_BITS      = 3;
   localparam int CC_REGS         = 3;
   localparam int COUNT_W         = 10;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 10;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
   localparam logic [3:0]         CC_STATUS_NIBBLE = 4'hB;

   localparam logic [CSR_INDEX_W-1:0] REG_MIDI_CHANNEL   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_VALUE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CC_BUTTON0     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CC_BUTTON1     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CC_BUTTON2     = 3'd5;

   localparam logic [3:0]         RST_MIDI_CHANNEL   = 4'd0;
   localparam logic [6:0]         RST_PRESS_VALUE    = 7'd127;
   localparam logic [COUNT_W-1:0] RST_DEBOUNCE_TICKS = 10'd30;
   localparam logic [6:0]         RST_CC_BUTTON0     = 7'd71;
   localparam logic [6:0]         RST_CC_BUTTON1     = 7'd72;
   localparam logic [6:0]         RST_CC_BUTTON2     = 7'd73;

   typedef struct packed {
      logic [3:0]                 midi_channel;
      logic [6:0]                 press_value;
      logic [COUNT_W-1:0]         debounce_ticks;
      logic [CC_REGS-1:0][6:0]    cc_button;
   } cfg_type;

endpackage

// ===== src/bdmc_lane.sv =====
// Debounce lane: raw reading history, settled level and saturating tick count of one button.
module bdmc_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        reading,
   input  logic [bdmc_pkg::COUNT_W-1:0] debounce_ticks,
   output logic                        press
);

   logic                         prev_ff;
   logic                         settled_ff;
   logic [bdmc_pkg::COUNT_W-1:0] count_ff;
   logic [bdmc_pkg::COUNT_W-1:0] count_in;
   logic                         settle;

   always_comb begin
      if (reading != prev_ff) begin
         count_in = '0;
      end else if (count_ff != bdmc_pkg::COUNT_MAX) begin
         count_in = count_ff + 1'b1;
      end else begin
         count_in = count_ff;
      end
      settle = (count_in > debounce_ticks) && (reading != settled_ff);
      press  = settle && !reading;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= 1'b1;
         settled_ff <= 1'b1;
         count_ff   <= '0;
      end else if (step) begin
         prev_ff  <= reading;
         count_ff <= count_in;
         if (settle) begin
            settled_ff <= reading;
         end
      end
   end

endmodule

// ===== src/bdmc_merge.sv =====
// Merge stage: queue one tick's press events, send one per cycle while rsp_ready is high, in button order.
module bdmc_merge #(
   parameter int NUM_EMIT = bdmc_pkg::CC_REGS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic [NUM_EMIT-1:0]     press,
   input  bdmc_pkg::cfg_type       cfg,
   output logic                    idle,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_button_index,
   output logic [7:0]              rsp_status_byte,
   output logic [6:0]              rsp_control_number,
   output logic [6:0]              rsp_control_value,
   output logic                    rsp_last_of_run
);

   logic [NUM_EMIT-1:0] pend_ff;
   logic [NUM_EMIT-1:0] pend_in;
   logic [NUM_EMIT-1:0] lowbit;
   logic [NUM_EMIT-1:0] rest;
   logic [1:0]          idx;
   logic                issue;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [1:0]          index_ff;
   logic [7:0]          status_ff;
   logic [6:0]          number_ff;
   logic [6:0]          value_ff;
   logic                last_ff;

   always_comb begin
      lowbit = pend_ff & (~pend_ff + 1'b1);
      rest   = pend_ff & ~lowbit;
      idx    = 2'd0;
      for (int k = 0; k < NUM_EMIT; k++) begin
         if (lowbit[k]) begin
            idx = idx | 2'(k);
         end
      end
      idle  = (pend_ff == '0);
      issue = !idle && (!rsp_valid_ff || rsp_ready);
      if (load) begin
         pend_in = press;
      end else if (issue) begin
         pend_in = rest;
      end else begin
         pend_in = pend_ff;
      end
      if (issue) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         index_ff  <= idx;
         status_ff <= {bdmc_pkg::CC_STATUS_NIBBLE, cfg.midi_channel};
         number_ff <= cfg.cc_button[idx];
         value_ff  <= cfg.press_value;
         last_ff   <= (rest == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_button_index   = index_ff;
   assign rsp_status_byte    = status_ff;
   assign rsp_control_number = number_ff;
   assign rsp_control_value  = value_ff;
   assign rsp_last_of_run    = last_ff;

endmodule

// ===== src/button_debounce_midi_cc.sv =====
// Top level of the debounced button to MIDI control-change block.
//
// Each req_ item is one millisecond tick carrying the raw active-low levels of
// the buttons in req_raw_levels. One debounce lane per button updates its
// reading history, tick count and settled level in the cycle the tick is
// accepted. Each of the first CC_REGS buttons that newly settles to pressed
// yields one rsp_ item: button index, status byte 0xB0 or channel, controller
// number and press value, with rsp_last_of_run set on the final item of that tick.
// The first event of a tick is loaded into the merge queue when the tick is
// accepted and then registered onto the rsp_ outputs; further events follow
// one per cycle while rsp_ready is high. req_ready stays low while the merge
// queue drains, so the next tick is accepted only once the queue is empty.
// The csr_ port writes a register at each edge with csr_wr_en high; indexes
// above the list are ignored. Write only while the block is idle.
// Reset (synchronous) releases all buttons, clears counts, empties the queue
// and loads the register defaults. A stalled rsp_ item holds until taken, and
// the next tick is accepted once the queue is empty even while it waits.
module button_debounce_midi_cc #(
   parameter int NUM_BUTTONS = bdmc_pkg::NUM_BUTTONS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bdmc_pkg::INPUT_BITS-1:0]   req_raw_levels,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_button_index,
   output logic [7:0]                        rsp_status_byte,
   output logic [6:0]                        rsp_control_number,
   output logic [6:0]                        rsp_control_value,
   output logic                              rsp_last_of_run,
   input  logic                              csr_wr_en,
   input  logic [bdmc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bdmc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int NUM_EMIT = (NUM_BUTTONS < bdmc_pkg::CC_REGS) ? NUM_BUTTONS
                                                               : bdmc_pkg::CC_REGS;

   bdmc_pkg::cfg_type     cfg_ff;
   logic                  step;
   logic                  idle;
   logic [NUM_BUTTONS-1:0] press;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.midi_channel   <= bdmc_pkg::RST_MIDI_CHANNEL;
         cfg_ff.press_value    <= bdmc_pkg::RST_PRESS_VALUE;
         cfg_ff.debounce_ticks <= bdmc_pkg::RST_DEBOUNCE_TICKS;
         cfg_ff.cc_button[0]   <= bdmc_pkg::RST_CC_BUTTON0;
         cfg_ff.cc_button[1]   <= bdmc_pkg::RST_CC_BUTTON1;
         cfg_ff.cc_button[2]   <= bdmc_pkg::RST_CC_BUTTON2;
      end else if (csr_wr_en) begin
         case (csr_index)
            bdmc_pkg::REG_MIDI_CHANNEL:   cfg_ff.midi_channel   <= csr_wdata[3:0];
            bdmc_pkg::REG_PRESS_VALUE:    cfg_ff.press_value    <= csr_wdata[6:0];
            bdmc_pkg::REG_DEBOUNCE_TICKS: cfg_ff.debounce_ticks <= csr_wdata[9:0];
            bdmc_pkg::REG_CC_BUTTON0:     cfg_ff.cc_button[0]   <= csr_wdata[6:0];
            bdmc_pkg::REG_CC_BUTTON1:     cfg_ff.cc_button[1]   <= csr_wdata[6:0];
            bdmc_pkg::REG_CC_BUTTON2:     cfg_ff.cc_button[2]   <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = idle;
   assign step      = req_valid && idle;

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      logic reading;
      if (i < bdmc_pkg::INPUT_BITS) begin : g_pin
         assign reading = req_raw_levels[i];
      end else begin : g_none
         assign reading = 1'b1;
      end
      bdmc_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .step           (step),
         .reading        (reading),
         .debounce_ticks (cfg_ff.debounce_ticks),
         .press          (press[i])
      );
   end

   bdmc_merge #(
      .NUM_EMIT (NUM_EMIT)
   ) u_merge (
      .clock              (clock),
      .reset              (reset),
      .load               (step),
      .press              (press[NUM_EMIT-1:0]),
      .cfg                (cfg_ff),
      .idle               (idle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_button_index   (rsp_button_index),
      .rsp_status_byte    (rsp_status_byte),
      .rsp_control_number (rsp_control_number),
      .rsp_control_value  (rsp_control_value),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

// ===== src/bdmc_checker.sv =====
// Port-level assertions of the debounced button CC block, bound to its top level.
module bdmc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_button_index,
   input logic [7:0] rsp_status_byte,
   input logic [6:0] rsp_control_number,
   input logic [6:0] rsp_control_value,
   input logic       rsp_last_of_run
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_button_index)
         && $stable(rsp_status_byte) && $stable(rsp_control_number)
         && $stable(rsp_control_value) && $stable(rsp_last_of_run))
      else $error("stalled item changed");

   a_status_cc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status_byte[7:4] == bdmc_pkg::CC_STATUS_NIBBLE
         && rsp_button_index != 2'd3)
      else $error("bad status byte or button index");

   a_run_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("gap inside a run of events");

endmodule

bind button_debounce_midi_cc bdmc_checker u_bdmc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_button_index   (rsp_button_index),
   .rsp_status_byte    (rsp_status_byte),
   .rsp_control_number (rsp_control_number),
   .rsp_control_value  (rsp_control_value),
   .rsp_last_of_run    (rsp_last_of_run)
);
